// File: hw/rtl/chpe_pkg.sv
// chpe_pkg: shared types and constants for the caption hex payload expander
// depends on nothing; used by the channel interfaces and the top level

package chpe_pkg;

	localparam int unsigned SymW  = 8;
	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 5;   // longest run is nine triples, 27 bytes

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_UNKNOWN  = 2'd1,
		ERR_LONE_HEX = 2'd2
	} err_code_t;

	// work decoded from one accepted character
	typedef struct packed {
		logic              err2;      // lone digit error result goes first
		logic              body_err;  // body is a single unrecognized-character result
		logic [LenW-1:0]   body_len;  // byte results in the body; 1 for an error body
		logic [ByteW-1:0]  b0;
		logic [ByteW-1:0]  b1;
		logic [ByteW-1:0]  b2;
	} job_t;

endpackage

// File: hw/rtl/chpe_in_if.sv
// chpe_in_if: input channel carrying one payload character per beat
// depends on chpe_pkg

interface chpe_in_if import chpe_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [SymW-1:0] symbol;
	logic            token_end;

	modport source (output valid, output symbol, output token_end, input ready);
	modport sink (input valid, input symbol, input token_end, output ready);
endinterface

// File: hw/rtl/chpe_out_if.sv
// chpe_out_if: output channel carrying one decoded result per beat
// depends on chpe_pkg

interface chpe_out_if import chpe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             byte_valid;
	logic [ByteW-1:0] out_byte;
	err_code_t        error_code;
	logic             run_last;

	modport source (output valid, output byte_valid, output out_byte, output error_code,
		output run_last, input ready);
	modport sink (input valid, input byte_valid, input out_byte, input error_code,
		input run_last, output ready);
endinterface

// File: hw/rtl/caption_hex_payload_expander.sv
// caption_hex_payload_expander: decodes a compressed caption payload token
// a character's first result passes the expansion stage, then the output register
// throughput: one character per cycle if the output is not stalled and each
//   yields one result at most; further results keep the expansion stage busy
// arst_n clears the held digit, expansion stage state and output valid, not data
// depends on chpe_pkg, chpe_in_if, chpe_out_if

module caption_hex_payload_expander import chpe_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	chpe_in_if.sink        chars,
	chpe_out_if.source     results
);

	localparam logic [SymW-1:0] ChG = 8'h47;
	localparam logic [SymW-1:0] ChO = 8'h4F;
	localparam logic [SymW-1:0] ChP = 8'h50;
	localparam logic [SymW-1:0] ChQ = 8'h51;
	localparam logic [SymW-1:0] ChR = 8'h52;
	localparam logic [SymW-1:0] ChS = 8'h53;
	localparam logic [SymW-1:0] ChT = 8'h54;
	localparam logic [SymW-1:0] ChU = 8'h55;
	localparam logic [SymW-1:0] ChZ = 8'h5A;

	// held digit
	logic       pend_q;
	logic [3:0] nib_q;

	// expansion stage
	logic            valid_s1;
	job_t            job_s1;
	logic [LenW-1:0] rem_s1;
	logic [1:0]      phase_s1;
	logic            err2_s1;

	// output register
	logic             ovalid_q;
	logic             obv_q;
	logic [ByteW-1:0] obyte_q;
	err_code_t        oerr_q;
	logic             olast_q;

	// decode
	logic            is_hex;
	logic [3:0]      hex_val;
	job_t            body;
	job_t            job_d;
	logic            job_has;
	logic [3:0]      run_k;
	logic            accept;

	always_comb begin
		is_hex  = 1'b0;
		hex_val = '0;
		if (chars.symbol >= 8'h30 && chars.symbol <= 8'h39) begin
			is_hex  = 1'b1;
			hex_val = chars.symbol[3:0];
		end else if ((chars.symbol >= 8'h41 && chars.symbol <= 8'h46) ||
				(chars.symbol >= 8'h61 && chars.symbol <= 8'h66)) begin
			is_hex  = 1'b1;
			hex_val = chars.symbol[3:0] + 4'd9;
		end
	end

	assign run_k = 4'(chars.symbol - 8'h46);

	// expansion of a non-hex character
	always_comb begin
		body = '0;
		if (chars.symbol >= ChG && chars.symbol <= ChO) begin
			body.body_len = 5'({run_k, 1'b0}) + 5'(run_k);
			body.b0       = 8'hFA;
		end else begin
			unique case (chars.symbol)
				ChP: begin
					body.body_len = 5'd3;
					body.b0 = 8'hFB; body.b1 = 8'h80; body.b2 = 8'h80;
				end
				ChQ: begin
					body.body_len = 5'd3;
					body.b0 = 8'hFC; body.b1 = 8'h80; body.b2 = 8'h80;
				end
				ChR: begin
					body.body_len = 5'd3;
					body.b0 = 8'hFD; body.b1 = 8'h80; body.b2 = 8'h80;
				end
				ChS: begin
					body.body_len = 5'd2;
					body.b0 = 8'h96; body.b1 = 8'h69;
				end
				ChT: begin
					body.body_len = 5'd2;
					body.b0 = 8'h61; body.b1 = 8'h01;
				end
				ChU: begin
					body.body_len = 5'd3;
					body.b0 = 8'hE1;
				end
				ChZ: begin
					body.body_len = 5'd1;
				end
				default: begin
					body.body_err = 1'b1;
					body.body_len = 5'd1;
				end
			endcase
		end
	end

	always_comb begin
		job_d   = '0;
		job_has = 1'b1;
		priority if (pend_q && is_hex) begin
			job_d.body_len = 5'd1;
			job_d.b0       = {nib_q, hex_val};
		end else if (pend_q) begin
			job_d      = body;
			job_d.err2 = 1'b1;
		end else if (is_hex) begin
			job_d.err2 = 1'b1;
			job_has    = chars.token_end;
		end else begin
			job_d = body;
		end
	end

	// emit side of the expansion stage
	logic             emit_fire;
	logic             emit_last;
	logic             e_bv;
	logic [ByteW-1:0] e_byte;
	err_code_t        e_err;

	always_comb begin
		e_bv   = 1'b0;
		e_byte = '0;
		e_err  = ERR_NONE;
		priority if (err2_s1) begin
			e_err     = ERR_LONE_HEX;
			emit_last = (rem_s1 == '0);
		end else if (job_s1.body_err) begin
			e_err     = ERR_UNKNOWN;
			emit_last = 1'b1;
		end else begin
			e_bv = 1'b1;
			unique case (phase_s1)
				2'd0:    e_byte = job_s1.b0;
				2'd1:    e_byte = job_s1.b1;
				default: e_byte = job_s1.b2;
			endcase
			emit_last = (rem_s1 == 5'd1);
		end
	end

	assign emit_fire    = valid_s1 && (!ovalid_q || results.ready);
	assign chars.ready  = !valid_s1 || (emit_fire && emit_last);
	assign accept       = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			nib_q  <= '0;
		end else if (accept) begin
			if (!pend_q && is_hex && !chars.token_end) begin
				pend_q <= 1'b1;
				nib_q  <= hex_val;
			end else begin
				pend_q <= 1'b0;
				nib_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			err2_s1  <= 1'b0;
			rem_s1   <= '0;
			phase_s1 <= '0;
		end else if (accept && job_has) begin
			valid_s1 <= 1'b1;
			err2_s1  <= job_d.err2;
			rem_s1   <= job_d.body_len;
			phase_s1 <= '0;
		end else if (emit_fire) begin
			if (emit_last) begin
				valid_s1 <= 1'b0;
			end
			if (err2_s1) begin
				err2_s1 <= 1'b0;
			end else begin
				rem_s1   <= rem_s1 - 5'd1;
				phase_s1 <= (phase_s1 == 2'd2) ? 2'd0 : phase_s1 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && job_has) begin
			job_s1 <= job_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_fire) begin
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			obv_q   <= e_bv;
			obyte_q <= e_byte;
			oerr_q  <= e_err;
			olast_q <= emit_last;
		end
	end

	assign results.valid      = ovalid_q;
	assign results.byte_valid = obv_q;
	assign results.out_byte   = obyte_q;
	assign results.error_code = oerr_q;
	assign results.run_last   = olast_q;

endmodule

// File: bench/tb.sv
// tb: self-checking bench for caption_hex_payload_expander, driving payload characters
// and checking every decoded byte and error result against an in-bench decoder
// depends on chpe_pkg, chpe_in_if, chpe_out_if and the expander top level

`timescale 1ns / 100ps

module tb;
	import chpe_pkg::*;

	localparam int StallLimit = 3000;

	typedef struct packed {
		logic             byte_valid;
		logic [ByteW-1:0] out_byte;
		err_code_t        error_code;
		logic             run_last;
	} decoded_t;

	logic clk;
	logic arst_n;

	chpe_in_if  in_ch ();
	chpe_out_if out_ch ();

	caption_hex_payload_expander uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (in_ch),
		.results (out_ch)
	);

	decoded_t decoded_q[$];
	decoded_t char_results[$];
	logic     digit_held = 1'b0;
	logic [3:0] held_nib = 4'h0;

	int    errors = 0;
	int    chars_sent = 0;
	int    stall_left = 0;
	int    idle_cycles = 0;
	bit    no_gaps = 1'b0;
	string hex_digits = "0123456789ABCDEFabcdef";
	string run_letters = "GHIJKLMNOPQRSTUZ";

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// decoder of the payload characters
	function automatic void add_result(logic bv, logic [ByteW-1:0] b, err_code_t e);
		decoded_t r;
		r.byte_valid = bv;
		r.out_byte   = b;
		r.error_code = e;
		r.run_last   = 1'b0;
		char_results.push_back(r);
	endfunction

	function automatic void add_triple(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		add_result(1'b1, b0, ERR_NONE);
		add_result(1'b1, b1, ERR_NONE);
		add_result(1'b1, b2, ERR_NONE);
	endfunction

	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9")
			v = 4'(c - "0");
		else if (c >= "A" && c <= "F")
			v = 4'(c - "A" + 10);
		else if (c >= "a" && c <= "f")
			v = 4'(c - "a" + 10);
		else
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic void add_expansion(logic [7:0] c);
		if (c >= "G" && c <= "O") begin
			// G is one FA 00 00 triple, O is nine
			for (int k = 0; k <= int'(c) - int'("G"); k++)
				add_triple(8'hFA, 8'h00, 8'h00);
		end else begin
			case (c)
				"P": add_triple(8'hFB, 8'h80, 8'h80);
				"Q": add_triple(8'hFC, 8'h80, 8'h80);
				"R": add_triple(8'hFD, 8'h80, 8'h80);
				"S": begin
					add_result(1'b1, 8'h96, ERR_NONE);
					add_result(1'b1, 8'h69, ERR_NONE);
				end
				"T": begin
					add_result(1'b1, 8'h61, ERR_NONE);
					add_result(1'b1, 8'h01, ERR_NONE);
				end
				"U": add_triple(8'hE1, 8'h00, 8'h00);
				"Z": add_result(1'b1, 8'h00, ERR_NONE);
				default: add_result(1'b0, 8'h00, ERR_UNKNOWN);
			endcase
		end
	endfunction

	function automatic void decode_symbol(logic [7:0] c, logic tend);
		logic [3:0] nib;
		bit is_hex;
		char_results.delete();
		is_hex = hex_nibble(c, nib);
		if (digit_held) begin
			if (is_hex) begin
				add_result(1'b1, {held_nib, nib}, ERR_NONE);
			end else begin
				add_result(1'b0, 8'h00, ERR_LONE_HEX);
				add_expansion(c);
			end
			digit_held = 1'b0;
			held_nib = 4'h0;
		end else if (is_hex) begin
			if (tend) begin
				add_result(1'b0, 8'h00, ERR_LONE_HEX);
			end else begin
				digit_held = 1'b1;
				held_nib = nib;
			end
		end else begin
			add_expansion(c);
		end
		if (tend) begin
			digit_held = 1'b0;
			held_nib = 4'h0;
		end
		if (char_results.size() > 0)
			char_results[char_results.size() - 1].run_last = 1'b1;
		foreach (char_results[i])
			decoded_q.push_back(char_results[i]);
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report(input string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// one character beat; entered and left at a falling edge
	task automatic send_char(input logic [7:0] sym, input logic tend);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.symbol    <= sym;
		in_ch.token_end <= tend;
		do
			@(posedge clk);
		while (!in_ch.ready);
		decode_symbol(sym, tend);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (decoded_q.size() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_hex();
		return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
	endfunction

	task automatic send_random_token();
		logic [7:0] sym_q[$];
		int units;
		int kind;
		units = $urandom_range(1, 6);
		repeat (units) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				sym_q.push_back(pick_hex());
				sym_q.push_back(pick_hex());
			end else if (kind < 85) begin
				sym_q.push_back(run_letters[$urandom_range(0, run_letters.len() - 1)]);
			end else if (kind < 93) begin
				sym_q.push_back(pick_hex());
			end else begin
				sym_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (sym_q[i])
			send_char(sym_q[i], i == sym_q.size() - 1);
	endtask

	task automatic test_hex_pairs();
		send_char("0", 1'b0);
		send_char("9", 1'b0);
		send_char("A", 1'b0);
		send_char("f", 1'b1);
		send_char("a", 1'b0);
		send_char("F", 1'b1);
	endtask

	task automatic test_expansions();
		send_char("G", 1'b0);
		send_char("O", 1'b0);
		send_char("P", 1'b0);
		send_char("Q", 1'b0);
		send_char("R", 1'b0);
		send_char("S", 1'b0);
		send_char("T", 1'b0);
		send_char("U", 1'b0);
		send_char("Z", 1'b1);
	endtask

	task automatic test_dropped_digits();
		// held digit then the longest run: error plus 27 bytes
		send_char("5", 1'b0);
		send_char("O", 1'b0);
		send_char("7", 1'b0);
		send_char(8'hFF, 1'b1);
		// upper-case hex letter alone at token end
		send_char("E", 1'b1);
	endtask

	task automatic test_unknown_symbols();
		send_char(8'h00, 1'b0);
		send_char("g", 1'b0);
		send_char(" ", 1'b0);
		send_char(8'h80, 1'b0);
		send_char("V", 1'b1);
	endtask

	task automatic test_random_tokens();
		bit paused;
		paused = 1'b0;
		while (chars_sent < 115) begin
			send_random_token();
			if (!paused && chars_sent >= 85) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_back_to_back();
		int stop_at;
		stop_at = chars_sent + 30;
		no_gaps = 1'b1;
		while (chars_sent < stop_at)
			send_random_token();
		no_gaps = 1'b0;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.byte_valid = out_ch.byte_valid;
			got.out_byte   = out_ch.out_byte;
			got.error_code = out_ch.error_code;
			got.run_last   = out_ch.run_last;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected result beat bv=%b byte=%h err=%0d last=%b",
					got.byte_valid, got.out_byte, got.error_code, got.run_last));
			end else begin
				want = decoded_q.pop_front();
				if (got.byte_valid !== want.byte_valid)
					report($sformatf("byte_valid %b, want %b", got.byte_valid,
						want.byte_valid));
				if (got.out_byte !== want.out_byte)
					report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
				if (got.error_code !== want.error_code)
					report($sformatf("error_code %0d, want %0d", got.error_code,
						want.error_code));
				if (got.run_last !== want.run_last)
					report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.symbol    = 8'h00;
		in_ch.token_end = 1'b0;
		out_ch.ready    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_hex_pairs();
		test_expansions();
		test_dropped_digits();
		test_unknown_symbols();
		wait_drained();
		test_random_tokens();
		test_back_to_back();

		wait_drained();
		repeat (8) @(posedge clk);
		if (decoded_q.size() != 0)
			report($sformatf("%0d results never arrived", decoded_q.size()));
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
